// ===== src/tae_pkg.sv =====
`timescale 1ns / 1ps

package tae_pkg;

  // architectural sizes
  localparam int REG_COUNT = 16;
  localparam int MEM_WORDS = 1024;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // operation codes
  typedef enum logic [5:0] {
    K_ADC    = 6'd0,
    K_ADD_DM = 6'd1,
    K_ADD_NM = 6'd2,
    K_ADD_DI = 6'd3,
    K_ADD_NI = 6'd4,
    K_AND    = 6'd5,
    K_ASR_I  = 6'd6,
    K_ASR_R  = 6'd7,
    K_BIC    = 6'd8,
    K_MOV_R  = 6'd9,
    K_EOR    = 6'd10,
    K_LSL_I  = 6'd11,
    K_LSL_R  = 6'd12,
    K_LSR_I  = 6'd13,
    K_LSR_R  = 6'd14,
    K_MOV_I  = 6'd15,
    K_MUL    = 6'd16,
    K_MVN    = 6'd17,
    K_NEG    = 6'd18,
    K_ORR    = 6'd19,
    K_ROR    = 6'd20,
    K_SBC    = 6'd21,
    K_SUB_DI = 6'd22,
    K_SUB_NI = 6'd23,
    K_SUB_DM = 6'd24,
    K_SUB_NM = 6'd25,
    K_LDR    = 6'd26,
    K_STR    = 6'd27,
    K_LDRB   = 6'd28,
    K_STRB   = 6'd29,
    K_LDRH   = 6'd30,
    K_STRH   = 6'd31,
    K_LDRSB  = 6'd32
  } kind_e;

  // barrel shifter operations
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  // execute result and write controls
  typedef struct packed {
    logic [31:0] result;
    logic        carry;
    logic        rf_we;
    logic        mem_we;
  } ex_t;

  // three-operand forms take their first operand from src_a instead of dest
  function automatic logic uses_src_a(input logic [5:0] kind);
    uses_src_a = (kind == K_ADD_NM) || (kind == K_ADD_NI) ||
                 (kind == K_SUB_NI) || (kind == K_SUB_NM);
  endfunction

endpackage

// ===== src/tae_if.sv =====
`timescale 1ns / 1ps

// decoded operation channel
interface tae_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [3:0]  dest_reg;
  logic [3:0]  src_a_reg;
  logic [3:0]  src_b_reg;
  logic [7:0]  immediate;
  logic [9:0]  mem_addr;

  modport source (
    output valid, kind, dest_reg, src_a_reg, src_b_reg, immediate, mem_addr,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_reg, src_a_reg, src_b_reg, immediate, mem_addr,
    output ready
  );
endinterface

// result channel
interface tae_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        carry_out;

  modport source (
    output valid, result_value, carry_out,
    input  ready
  );
  modport sink (
    input  valid, result_value, carry_out,
    output ready
  );
endinterface

// ===== src/tae_regfile.sv =====
`timescale 1ns / 1ps

module tae_regfile import tae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [3:0]  ra_a_i,
  input  logic [3:0]  ra_b_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o,
  input  logic        we_i,
  input  logic [3:0]  wa_i,
  input  logic [31:0] wd_i
);

  logic [31:0]          regs [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [31:0]          rdata_a_q;
  logic [31:0]          rdata_b_q;
  logic                 wr_ok;
  logic                 a_ok;
  logic                 b_ok;
  logic [REG_AW-1:0]    wa_idx;
  logic [REG_AW-1:0]    a_idx;
  logic [REG_AW-1:0]    b_idx;

  // index range checks
  assign wr_ok  = we_i && (32'(wa_i) < REG_COUNT);
  assign a_ok   = 32'(ra_a_i) < REG_COUNT;
  assign b_ok   = 32'(ra_b_i) < REG_COUNT;
  assign wa_idx = REG_AW'(wa_i);
  assign a_idx  = REG_AW'(ra_a_i);
  assign b_idx  = REG_AW'(ra_b_i);

  // storage, entries read as zero until first written
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      regs[wa_idx] <= wd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_ok) begin
      vld_q[wa_idx] <= 1'b1;
    end
  end

  // registered reads with write-through of the same-edge write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (!a_ok) begin
        rdata_a_q <= '0;
      end else if (wr_ok && (wa_idx == a_idx)) begin
        rdata_a_q <= wd_i;
      end else begin
        rdata_a_q <= vld_q[a_idx] ? regs[a_idx] : '0;
      end
      if (!b_ok) begin
        rdata_b_q <= '0;
      end else if (wr_ok && (wa_idx == b_idx)) begin
        rdata_b_q <= wd_i;
      end else begin
        rdata_b_q <= vld_q[b_idx] ? regs[b_idx] : '0;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/tae_dmem.sv =====
`timescale 1ns / 1ps

module tae_dmem import tae_pkg::*; (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic [9:0]  raddr_i,
  output logic [31:0] rdata_o,
  input  logic        we_i,
  input  logic [9:0]  waddr_i,
  input  logic [31:0] wdata_i
);

  logic [31:0]       mem [MEM_WORDS];
  logic [31:0]       mem_q;
  logic [31:0]       fwd_data_q;
  logic              fwd_q;
  logic              rng_q;
  logic              wr_ok;
  logic              rd_ok;
  logic [MEM_AW-1:0] w_idx;
  logic [MEM_AW-1:0] r_idx;

  assign wr_ok = we_i && (32'(waddr_i) < MEM_WORDS);
  assign rd_ok = 32'(raddr_i) < MEM_WORDS;
  assign w_idx = MEM_AW'(waddr_i);
  assign r_idx = MEM_AW'(raddr_i);

  // word array
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[w_idx] <= wdata_i;
    end
  end

  // registered read, plus bypass of a store at the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_q      <= mem[r_idx];
      fwd_q      <= wr_ok && (w_idx == r_idx);
      fwd_data_q <= wdata_i;
      rng_q      <= rd_ok;
    end
  end

  assign rdata_o = !rng_q ? '0 : (fwd_q ? fwd_data_q : mem_q);

endmodule

// ===== src/tae_shifter.sv =====
`timescale 1ns / 1ps

module tae_shifter import tae_pkg::*; (
  input  shift_e      op_i,
  input  logic [31:0] val_i,
  input  logic [7:0]  amt_i,
  input  logic        cin_i,
  output logic [31:0] res_o,
  output logic        cout_o
);

  logic [4:0]  k;
  logic        big;
  logic        is32;
  logic [32:0] lsl_p;
  logic [32:0] lsr_p;
  logic [32:0] asr_p;
  logic [63:0] ror_p;

  assign k    = amt_i[4:0];
  assign big  = |amt_i[7:5];
  assign is32 = (amt_i == 8'd32);

  // one extra bit beside the word catches the last bit shifted out
  assign lsl_p = {1'b0, val_i} << k;
  assign lsr_p = {val_i, 1'b0} >> k;
  assign asr_p = 33'($signed({val_i, 1'b0}) >>> k);
  assign ror_p = {val_i, val_i} >> k;

  always_comb begin
    res_o  = val_i;
    cout_o = cin_i;
    if (amt_i != 8'd0) begin
      unique case (op_i)
        SH_LSL: begin
          if (!big) begin
            res_o  = lsl_p[31:0];
            cout_o = lsl_p[32];
          end else begin
            res_o  = '0;
            cout_o = is32 ? val_i[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (!big) begin
            res_o  = lsr_p[32:1];
            cout_o = lsr_p[0];
          end else begin
            res_o  = '0;
            cout_o = is32 ? val_i[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (!big) begin
            res_o  = asr_p[32:1];
            cout_o = asr_p[0];
          end else begin
            res_o  = {32{val_i[31]}};
            cout_o = val_i[31];
          end
        end
        SH_ROR: begin
          res_o  = ror_p[31:0];
          cout_o = ror_p[31];
        end
        default: begin
          res_o  = val_i;
          cout_o = cin_i;
        end
      endcase
    end
  end

endmodule

// ===== src/tae_alu.sv =====
`timescale 1ns / 1ps

module tae_alu import tae_pkg::*; (
  input  logic [5:0]  kind_i,
  input  logic [7:0]  imm_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  input  logic [31:0] mem_i,
  input  logic        carry_i,
  output ex_t         ex_o
);

  logic [31:0] imm32;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_ci;
  logic [31:0] sum;
  logic [31:0] mul_lo;
  shift_e      sh_op;
  logic [31:0] sh_val;
  logic [7:0]  sh_amt;
  logic [31:0] sh_res;
  logic        sh_c;

  assign imm32 = {24'b0, imm_i};

  // shared adder operand selection
  always_comb begin
    add_a  = op_a_i;
    add_b  = op_b_i;
    add_ci = 1'b0;
    case (kind_i) inside
      K_ADC: begin
        add_ci = carry_i;
      end
      K_ADD_DI, K_ADD_NI: begin
        add_b = imm32;
      end
      K_SBC: begin
        add_b  = ~op_b_i;
        add_ci = carry_i;
      end
      K_SUB_DI, K_SUB_NI: begin
        add_b  = ~imm32;
        add_ci = 1'b1;
      end
      K_SUB_DM, K_SUB_NM: begin
        add_b  = ~op_b_i;
        add_ci = 1'b1;
      end
      K_NEG: begin
        add_a  = '0;
        add_b  = ~op_b_i;
        add_ci = 1'b1;
      end
      default: begin
        add_a  = op_a_i;
        add_b  = op_b_i;
        add_ci = 1'b0;
      end
    endcase
  end

  assign sum    = add_a + add_b + 32'(add_ci);
  assign mul_lo = op_a_i * op_b_i;

  // shifter operand selection: immediate forms shift rm, register forms shift rd by rs
  always_comb begin
    sh_op  = SH_LSL;
    sh_val = op_a_i;
    sh_amt = op_b_i[7:0];
    case (kind_i) inside
      K_ASR_I: begin
        sh_op  = SH_ASR;
        sh_val = op_b_i;
        sh_amt = imm_i;
      end
      K_ASR_R: sh_op = SH_ASR;
      K_LSL_I: begin
        sh_val = op_b_i;
        sh_amt = imm_i;
      end
      K_LSR_I: begin
        sh_op  = SH_LSR;
        sh_val = op_b_i;
        sh_amt = imm_i;
      end
      K_LSR_R: sh_op = SH_LSR;
      K_ROR:   sh_op = SH_ROR;
      default: sh_op = SH_LSL;
    endcase
  end

  tae_shifter u_shifter (
    .op_i   (sh_op),
    .val_i  (sh_val),
    .amt_i  (sh_amt),
    .cin_i  (carry_i),
    .res_o  (sh_res),
    .cout_o (sh_c)
  );

  // result decode
  always_comb begin
    ex_o.result = '0;
    ex_o.carry  = carry_i;
    ex_o.rf_we  = 1'b1;
    ex_o.mem_we = 1'b0;
    unique case (kind_i) inside
      K_ADC, K_ADD_DM, K_ADD_NM, K_ADD_DI, K_ADD_NI, K_SBC,
      K_SUB_DI, K_SUB_NI, K_SUB_DM, K_SUB_NM, K_NEG: ex_o.result = sum;
      K_AND:   ex_o.result = op_a_i & op_b_i;
      K_BIC:   ex_o.result = op_a_i & ~op_b_i;
      K_EOR:   ex_o.result = op_a_i ^ op_b_i;
      K_ORR:   ex_o.result = op_a_i | op_b_i;
      K_MOV_R: ex_o.result = op_b_i;
      K_MVN:   ex_o.result = ~op_b_i;
      K_MOV_I: ex_o.result = imm32;
      K_MUL:   ex_o.result = mul_lo;
      K_ASR_I, K_ASR_R, K_LSL_I, K_LSL_R, K_LSR_I, K_LSR_R, K_ROR: begin
        ex_o.result = sh_res;
        ex_o.carry  = sh_c;
      end
      K_LDR:   ex_o.result = mem_i;
      K_LDRB:  ex_o.result = {24'b0, mem_i[7:0]};
      K_LDRH:  ex_o.result = {16'b0, mem_i[15:0]};
      K_LDRSB: ex_o.result = {{24{mem_i[7]}}, mem_i[7:0]};
      K_STR: begin
        ex_o.result = op_a_i;
        ex_o.rf_we  = 1'b0;
        ex_o.mem_we = 1'b1;
      end
      K_STRB: begin
        ex_o.result = {24'b0, op_a_i[7:0]};
        ex_o.rf_we  = 1'b0;
        ex_o.mem_we = 1'b1;
      end
      K_STRH: begin
        ex_o.result = {16'b0, op_a_i[15:0]};
        ex_o.rf_we  = 1'b0;
        ex_o.mem_we = 1'b1;
      end
      default: begin
        // unused codes change nothing
        ex_o.result = '0;
        ex_o.rf_we  = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/thumb_alu_execute_unit.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake             | payload
// op_i    | in  | op_i.valid/op_i.ready | kind, dest_reg, src_a_reg, src_b_reg,
//         |     |                       | immediate, mem_addr
// res_o   | out | res_o.valid/res_o.ready | result_value, carry_out
//
// one item per cycle while the result is not stalled; a taken item passes through
// the operand read registers, loaded at the accept edge, then execute into the result register
// register file and data memory are read at the accept edge, with bypass of the
// write made by the item in execute at that same edge
// reset clears the carry, the register valid bits and the pipeline; memory is
// undefined until written
// a stalled result holds execute; a new item is still taken while execute is empty
module thumb_alu_execute_unit import tae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tae_in_if.sink    op_i,
  tae_res_if.source res_o
);

  logic        in_acc;
  logic        ex_adv;
  logic        ex_vld_q;
  logic [5:0]  ex_kind_q;
  logic [3:0]  ex_dest_q;
  logic [7:0]  ex_imm_q;
  logic [9:0]  ex_addr_q;
  logic        carry_q;
  logic        out_vld_q;
  logic [31:0] out_res_q;
  logic        out_carry_q;
  logic [3:0]  ra_a;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] mem_data;
  ex_t         ex;

  // pipeline flow
  assign ex_adv     = ex_vld_q && (!out_vld_q || res_o.ready);
  assign op_i.ready = !ex_vld_q || ex_adv;
  assign in_acc     = op_i.valid && op_i.ready;
  assign ra_a       = uses_src_a(op_i.kind) ? op_i.src_a_reg : op_i.dest_reg;

  tae_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .ra_a_i    (ra_a),
    .ra_b_i    (op_i.src_b_reg),
    .rdata_a_o (op_a),
    .rdata_b_o (op_b),
    .we_i      (ex_adv && ex.rf_we),
    .wa_i      (ex_dest_q),
    .wd_i      (ex.result)
  );

  tae_dmem u_dmem (
    .clk_i   (clk_i),
    .rd_en_i (in_acc),
    .raddr_i (op_i.mem_addr),
    .rdata_o (mem_data),
    .we_i    (ex_adv && ex.mem_we),
    .waddr_i (ex_addr_q),
    .wdata_i (ex.result)
  );

  tae_alu u_alu (
    .kind_i  (ex_kind_q),
    .imm_i   (ex_imm_q),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .mem_i   (mem_data),
    .carry_i (carry_q),
    .ex_o    (ex)
  );

  // execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else if (op_i.ready) begin
      ex_vld_q <= op_i.valid;
    end
  end

  // execute stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_kind_q <= op_i.kind;
      ex_dest_q <= op_i.dest_reg;
      ex_imm_q  <= op_i.immediate;
      ex_addr_q <= op_i.mem_addr;
    end
  end

  // carry flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
    end else if (ex_adv) begin
      carry_q <= ex.carry;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ex_adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      out_res_q   <= ex.result;
      out_carry_q <= ex.carry;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.result_value = out_res_q;
  assign res_o.carry_out    = out_carry_q;

  // checks
  a_ex_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_vld_q && !ex_adv |=> ex_vld_q)
    else $error("execute item dropped while stalled");

  a_acc_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ex_vld_q)
    else $error("accepted item missing from execute");

  a_carry_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_adv |=> $stable(carry_q))
    else $error("carry changed without an executed item");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(ex_adv))
    else $error("result appeared without an executed item");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |-> !ex_adv)
    else $error("result overwritten while waiting");

endmodule
